// File: design/ialu_pkg.sv
// shared types and operation codes for the 64-bit integer alu
package ialu_pkg;

	localparam int unsigned WordBits = 64;

	typedef logic [WordBits-1:0] word_t;

	typedef enum logic [4:0] {
		OP_NEG  = 5'd0,
		OP_NOT  = 5'd1,
		OP_LNOT = 5'd2,
		OP_ADD  = 5'd3,
		OP_SUB  = 5'd4,
		OP_MUL  = 5'd5,
		OP_DIVU = 5'd6,
		OP_DIVS = 5'd7,
		OP_REMU = 5'd8,
		OP_REMS = 5'd9,
		OP_AND  = 5'd10,
		OP_OR   = 5'd11,
		OP_XOR  = 5'd12,
		OP_SLL  = 5'd13,
		OP_SRL  = 5'd14,
		OP_SRA  = 5'd15,
		OP_EQ   = 5'd16,
		OP_NE   = 5'd17,
		OP_LTU  = 5'd18,
		OP_LEU  = 5'd19,
		OP_LTS  = 5'd20,
		OP_LES  = 5'd21,
		OP_GTU  = 5'd22,
		OP_GEU  = 5'd23,
		OP_GTS  = 5'd24,
		OP_GES  = 5'd25,
		OP_LAND = 5'd26,
		OP_LOR  = 5'd27
	} op_t;

	typedef struct packed {
		op_t   op;
		word_t res;
		logic  q_neg;
		logic  r_neg;
		logic  dz;
		logic  is_div;
		logic  is_rem;
	} meta_t;

	typedef struct packed {
		word_t r;
		word_t n;
		word_t d;
	} div_t;

endpackage

// File: design/ialu_req_if.sv
// request channel of the alu: operation and two operands
interface ialu_req_if;
	import ialu_pkg::*;
	logic  valid;
	logic  ready;
	op_t   operation;
	word_t operand_a;
	word_t operand_b;
	modport source (output valid, output operation, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input operation, input operand_a, input operand_b,
		output ready);
endinterface

// File: design/ialu_rsp_if.sv
// response channel of the alu: one 64-bit result
interface ialu_rsp_if;
	import ialu_pkg::*;
	logic  valid;
	logic  ready;
	word_t result;
	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

// File: design/ialu_front.sv
// input register, simple operations, multiplier partial products and divider setup
module ialu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  ialu_pkg::op_t    op,
	input  ialu_pkg::word_t  a,
	input  ialu_pkg::word_t  b,
	output logic             v_out,
	output ialu_pkg::meta_t  meta_out,
	output ialu_pkg::div_t   div_out
);
	import ialu_pkg::*;

	logic  v_s1, v_s2, v_s3;
	op_t   op_s1;
	word_t a_s1, b_s1;
	meta_t meta_s2, meta_s3;
	div_t  div_s2, div_s3;
	word_t pp0_s2;
	logic [31:0] pp1_s2, pp2_s2;

	word_t res_c;
	meta_t meta_c;
	div_t  div_c;
	logic  wide_sh, sgn, lts, gts;
	word_t sra_c, mul_c, pp0_c;
	logic [31:0] mid_c;
	meta_t meta_mul_c;

	always_comb begin
		wide_sh = b_s1[63:6] != '0;
		lts = $signed(a_s1) < $signed(b_s1);
		gts = $signed(b_s1) < $signed(a_s1);
		sra_c = wide_sh ? {WordBits{a_s1[63]}} : word_t'($signed(a_s1) >>> b_s1[5:0]);
		case (op_s1)
			OP_NEG:  res_c = ~a_s1 + word_t'(1);
			OP_NOT:  res_c = ~a_s1;
			OP_LNOT: res_c = word_t'(a_s1 == '0);
			OP_ADD:  res_c = a_s1 + b_s1;
			OP_SUB:  res_c = a_s1 - b_s1;
			OP_AND:  res_c = a_s1 & b_s1;
			OP_OR:   res_c = a_s1 | b_s1;
			OP_XOR:  res_c = a_s1 ^ b_s1;
			OP_SLL:  res_c = wide_sh ? '0 : a_s1 << b_s1[5:0];
			OP_SRL:  res_c = wide_sh ? '0 : a_s1 >> b_s1[5:0];
			OP_SRA:  res_c = sra_c;
			OP_EQ:   res_c = word_t'(a_s1 == b_s1);
			OP_NE:   res_c = word_t'(a_s1 != b_s1);
			OP_LTU:  res_c = word_t'(a_s1 < b_s1);
			OP_LEU:  res_c = word_t'(a_s1 <= b_s1);
			OP_LTS:  res_c = word_t'(lts);
			OP_LES:  res_c = word_t'(!gts);
			OP_GTU:  res_c = word_t'(a_s1 > b_s1);
			OP_GEU:  res_c = word_t'(a_s1 >= b_s1);
			OP_GTS:  res_c = word_t'(gts);
			OP_GES:  res_c = word_t'(!lts);
			OP_LAND: res_c = word_t'(a_s1 != '0 && b_s1 != '0);
			OP_LOR:  res_c = word_t'(a_s1 != '0 || b_s1 != '0);
			default: res_c = '0;
		endcase
		sgn = op_s1 == OP_DIVS || op_s1 == OP_REMS;
		meta_c.op     = op_s1;
		meta_c.res    = res_c;
		meta_c.q_neg  = sgn && (a_s1[63] ^ b_s1[63]);
		meta_c.r_neg  = sgn && a_s1[63];
		meta_c.dz     = b_s1 == '0;
		meta_c.is_div = op_s1 == OP_DIVU || op_s1 == OP_DIVS;
		meta_c.is_rem = op_s1 == OP_REMU || op_s1 == OP_REMS;
		div_c.r = '0;
		div_c.n = (sgn && a_s1[63]) ? ~a_s1 + word_t'(1) : a_s1;
		div_c.d = (sgn && b_s1[63]) ? ~b_s1 + word_t'(1) : b_s1;
		pp0_c = {32'b0, a_s1[31:0]} * {32'b0, b_s1[31:0]};
	end

	// low word of the product from three partial products
	always_comb begin
		mid_c = pp1_s2 + pp2_s2;
		mul_c = pp0_s2 + {mid_c, 32'b0};
		meta_mul_c = meta_s2;
		if (meta_s2.op == OP_MUL) begin
			meta_mul_c.res = mul_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= op;
			a_s1    <= a;
			b_s1    <= b;
			meta_s2 <= meta_c;
			div_s2  <= div_c;
			pp0_s2  <= pp0_c;
			pp1_s2  <= 32'(a_s1[31:0] * b_s1[63:32]);
			pp2_s2  <= 32'(a_s1[63:32] * b_s1[31:0]);
			meta_s3 <= meta_mul_c;
			div_s3  <= div_s2;
		end
	end

	assign v_out    = v_s3;
	assign meta_out = meta_s3;
	assign div_out  = div_s3;

endmodule

// File: design/ialu_div_step.sv
// one restoring division step: one quotient bit per stage
module ialu_div_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  ialu_pkg::meta_t  meta_in,
	input  ialu_pkg::div_t   div_in,
	output logic             v_out,
	output ialu_pkg::meta_t  meta_out,
	output ialu_pkg::div_t   div_out
);
	import ialu_pkg::*;

	logic  v_q;
	meta_t meta_q;
	div_t  div_q;
	logic [WordBits:0] rr, diff;
	logic  ge;
	div_t  nxt;

	always_comb begin
		rr   = {div_in.r, div_in.n[WordBits-1]};
		diff = rr - {1'b0, div_in.d};
		ge   = !diff[WordBits];
		nxt.r = ge ? diff[WordBits-1:0] : rr[WordBits-1:0];
		nxt.n = {div_in.n[WordBits-2:0], ge};
		nxt.d = div_in.d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q <= meta_in;
			div_q  <= nxt;
		end
	end

	assign v_out    = v_q;
	assign meta_out = meta_q;
	assign div_out  = div_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && div_q.d != '0) |-> div_q.r < div_q.d)
		else $error("partial remainder not below divisor");

endmodule

// File: design/ialu_back.sv
// sign correction, divide-by-zero and result select into the output register
module ialu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  ialu_pkg::meta_t  meta_in,
	input  ialu_pkg::div_t   div_in,
	output logic             v_out,
	output ialu_pkg::word_t  res_out
);
	import ialu_pkg::*;

	logic  v_q;
	word_t res_q, quo, rem, sel;
	logic  cmp;

	always_comb begin
		quo = meta_in.q_neg ? ~div_in.n + word_t'(1) : div_in.n;
		rem = meta_in.r_neg ? ~div_in.r + word_t'(1) : div_in.r;
		if ((meta_in.is_div || meta_in.is_rem) && meta_in.dz) begin
			sel = '0;
		end else if (meta_in.is_div) begin
			sel = quo;
		end else if (meta_in.is_rem) begin
			sel = rem;
		end else begin
			sel = meta_in.res;
		end
		cmp = meta_in.op == OP_EQ || meta_in.op == OP_NE || meta_in.op == OP_LTU
			|| meta_in.op == OP_LEU || meta_in.op == OP_LTS || meta_in.op == OP_LES
			|| meta_in.op == OP_GTU || meta_in.op == OP_GEU || meta_in.op == OP_GTS
			|| meta_in.op == OP_GES || meta_in.op == OP_LAND || meta_in.op == OP_LOR
			|| meta_in.op == OP_LNOT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= sel;
		end
	end

	assign v_out   = v_q;
	assign res_out = res_q;

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_in && meta_in.dz && (meta_in.is_div || meta_in.is_rem)) |=> res_q == '0)
		else $error("divide by zero gave nonzero result");

	a_cmp_bool: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_in && cmp) |=> res_q[WordBits-1:1] == '0)
		else $error("comparison result not 0 or 1");

endmodule

// File: design/integer_alu_64.sv
// 64-bit integer alu, top level
//
//   channel | role   | fields
//   --------+--------+------------------------------------
//   req     | sink   | operation, operand_a, operand_b
//   rsp     | source | result
//
// every request passes 68 register stages: input, decode and partial
// products, product sum, 64 divider steps (one quotient bit each), output
// one request enters per cycle while the response is not stalled; the 64-stage divider sets the latency
// arst_n clears all valid bits; payload registers are not reset
// a stalled response freezes the whole pipeline; req.ready is low only then
module integer_alu_64 (
	input  logic clk,
	input  logic arst_n,
	ialu_req_if.sink   req,
	ialu_rsp_if.source rsp
);
	import ialu_pkg::*;

	localparam int unsigned Steps = WordBits;

	logic  en;
	logic  v_c [Steps+1];
	meta_t m_c [Steps+1];
	div_t  d_c [Steps+1];

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	ialu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (req.valid),
		.op       (req.operation),
		.a        (req.operand_a),
		.b        (req.operand_b),
		.v_out    (v_c[0]),
		.meta_out (m_c[0]),
		.div_out  (d_c[0])
	);

	for (genvar i = 0; i < Steps; i++) begin : g_div
		ialu_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (v_c[i]),
			.meta_in  (m_c[i]),
			.div_in   (d_c[i]),
			.v_out    (v_c[i+1]),
			.meta_out (m_c[i+1]),
			.div_out  (d_c[i+1])
		);
	end

	ialu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_c[Steps]),
		.meta_in (m_c[Steps]),
		.div_in  (d_c[Steps]),
		.v_out   (rsp.valid),
		.res_out (rsp.result)
	);

endmodule
